// ===== rtl/core/sbtm_pkg.sv =====
package sbtm_pkg;

  localparam int ROUNDS     = 10;
  localparam int ROUND_W    = 4;
  localparam int TRIM_SHIFT = 3;
  localparam int SAMPLE_W   = 12;
  localparam int SLOT_W     = 4;
  localparam int MEAN_W     = 12;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_TRIM_LO,
    ST_TRIM_HI
  } seq_state_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB_LO,
    ACC_SUB_HI
  } acc_op_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_status_t;

endpackage

// ===== rtl/core/sbtm_store.sv =====
module sbtm_store #(
  parameter int DEPTH  = 90,
  parameter int DATA_W = 12,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] wpos;
  logic              filled;
  logic [DATA_W-1:0] rd_q;
  logic              rd_valid;

  // entries below the write position, or all once wrapped, hold written data
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos   <= '0;
      filled <= 1'b0;
    end else if (wr_en) begin
      if (wpos == ADDR_W'(DEPTH - 1)) begin
        wpos   <= '0;
        filled <= 1'b1;
      end else begin
        wpos <= wpos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wpos] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_valid <= filled || (rd_addr < wpos);
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

// ===== rtl/core/sbtm_accum.sv =====
module sbtm_accum #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                      clk,
  input  sbtm_pkg::acc_op_t         op,
  input  logic [SAMPLE_BITS-1:0]    data,
  output logic [sbtm_pkg::MEAN_W-1:0] result
);
  import sbtm_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + ROUND_W;

  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       sum_next;
  logic [SUM_W-1:0]       base;
  logic [SUM_W-1:0]       opnd;
  logic                   sub;
  logic [SAMPLE_BITS-1:0] lo;
  logic [SAMPLE_BITS-1:0] hi;

  // one shared adder: sum +/- operand
  always_comb begin
    base = sum;
    opnd = SUM_W'(data);
    sub  = 1'b0;
    case (op)
      ACC_LOAD:   base = '0;
      ACC_SUB_LO: begin
        opnd = SUM_W'(lo);
        sub  = 1'b1;
      end
      ACC_SUB_HI: begin
        opnd = SUM_W'(hi);
        sub  = 1'b1;
      end
      default: ;
    endcase
    sum_next = base + (sub ? ~opnd : opnd) + SUM_W'(sub);
  end

  always_ff @(posedge clk) begin
    case (op)
      ACC_LOAD: begin
        sum <= sum_next;
        lo  <= data;
        hi  <= data;
      end
      ACC_ADD: begin
        sum <= sum_next;
        if (data < lo) lo <= data;
        if (data > hi) hi <= data;
      end
      ACC_SUB_LO, ACC_SUB_HI: sum <= sum_next;
      default: ;
    endcase
  end

  assign result = MEAN_W'(sum_next >> TRIM_SHIFT);

endmodule

// ===== rtl/core/sbtm_seq.sv =====
module sbtm_seq #(
  parameter int CHANNELS = 9,
  parameter int ADDR_W   = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sbtm_pkg::SLOT_W-1:0] slot,
  output logic                        rd_en,
  output logic [ADDR_W-1:0]           rd_addr,
  output sbtm_pkg::acc_op_t           acc_op,
  output sbtm_pkg::seq_status_t       status
);
  import sbtm_pkg::*;

  seq_state_t         state;
  seq_state_t         state_next;
  logic [ROUND_W-1:0] rnd;
  logic [ADDR_W-1:0]  addr;
  logic               rd_pend;
  logic               rd_first;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (start) state_next = ST_READ;
      ST_READ:    if (rnd == ROUND_W'(ROUNDS - 1)) state_next = ST_DRAIN;
      ST_DRAIN:   state_next = ST_TRIM_LO;
      ST_TRIM_LO: state_next = ST_TRIM_HI;
      ST_TRIM_HI: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_pend  <= 1'b0;
      rd_first <= 1'b0;
    end else begin
      state    <= state_next;
      rd_pend  <= (state == ST_READ);
      rd_first <= (state == ST_READ) && (rnd == '0);
    end
  end

  // slot of round r sits at r*CHANNELS+slot
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rnd  <= '0;
      addr <= ADDR_W'(slot);
    end else if (state == ST_READ) begin
      rnd  <= rnd + 1'b1;
      addr <= addr + ADDR_W'(CHANNELS);
    end
  end

  always_comb begin
    rd_en   = (state == ST_READ);
    rd_addr = addr;
    if (rd_pend) begin
      acc_op = rd_first ? ACC_LOAD : ACC_ADD;
    end else begin
      case (state)
        ST_TRIM_LO: acc_op = ACC_SUB_LO;
        ST_TRIM_HI: acc_op = ACC_SUB_HI;
        default:    acc_op = ACC_NONE;
      endcase
    end
    status.idle = (state == ST_IDLE);
    status.done = (state == ST_TRIM_HI);
  end

endmodule

// ===== rtl/core/scan_buffer_trimmed_mean_unit.sv =====
// Scan buffer with ten-round trimmed mean. A sample beat (op 0) is taken and
// written at the next position of a circular store of 10*CHANNELS entries.
// A read beat (op 1) for a valid slot walks the ten rounds of that slot
// through the store's single read port, one entry per cycle, into a shared
// add/compare unit; after a drain state and two trim subtractions the result
// is registered, and no input is taken meanwhile. A read for a slot at or
// above CHANNELS returns 0 on the next cycle. Entries not yet written read
// as zero by way of a write-position fill mark, so reset needs no clearing pass.
// The input is also taken while a result waits, if that result leaves at
// the same edge or the beat is a sample.
module scan_buffer_trimmed_mean_unit #(
  parameter int CHANNELS    = 9,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [sbtm_pkg::SAMPLE_W-1:0] sample,
  input  logic [sbtm_pkg::SLOT_W-1:0]   slot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sbtm_pkg::MEAN_W-1:0]   mean
);
  import sbtm_pkg::*;

  localparam int DEPTH  = ROUNDS * CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic                   in_acc;
  logic                   slot_ok;
  logic                   wr_en;
  logic                   start;
  logic                   bad_read;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  acc_op_t                acc_op;
  seq_status_t            status;
  logic [MEAN_W-1:0]      result;

  assign in_stall = !status.idle || (out_valid && out_stall && (op == OP_READ));
  assign in_acc   = in_valid && !in_stall;
  assign slot_ok  = {1'b0, slot} < (SLOT_W + 1)'(CHANNELS);
  assign wr_en    = in_acc && (op == OP_SAMPLE);
  assign start    = in_acc && (op == OP_READ) && slot_ok;
  assign bad_read = in_acc && (op == OP_READ) && !slot_ok;

  sbtm_store #(
    .DEPTH  (DEPTH),
    .DATA_W (SAMPLE_BITS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (sample[SAMPLE_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sbtm_seq #(
    .CHANNELS (CHANNELS),
    .ADDR_W   (ADDR_W)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .slot    (slot),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .acc_op  (acc_op),
    .status  (status)
  );

  sbtm_accum #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk    (clk),
    .op     (acc_op),
    .data   (rd_data),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (bad_read || status.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bad_read) begin
      mean <= '0;
    end else if (status.done) begin
      mean <= result;
    end
  end

  a_done_out_free: assert property (@(posedge clk) disable iff (rst)
    status.done |-> !(out_valid && out_stall))
    else $error("result finished while output beat still held");

  a_bad_slot_zero: assert property (@(posedge clk) disable iff (rst)
    bad_read |=> out_valid && (mean == '0))
    else $error("out-of-range slot did not return zero");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    !status.idle |-> !wr_en && !start)
    else $error("beat taken while sequencer busy");

endmodule
